// ----- design/sphm_pkg.sv -----
package sphm_pkg;

   // Geometry of the meter.
   localparam int FFT_POINTS = 64;
   localparam int NBINS      = 32;
   localparam int BIN_W      = $clog2(NBINS);

   // One signed component of a packed bin and its square.
   localparam int COMP_W = 16;
   localparam int WORD_W = 2 * COMP_W;
   localparam int SQ_W   = 2 * COMP_W;
   localparam int SUM_W  = SQ_W;

   // The root is taken of sum * 2^PRESCALE, then scaled down by the FFT size.
   localparam int PRESCALE  = 14;
   localparam int RAD_W     = SUM_W + PRESCALE;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int MAG_SHIFT = $clog2(FFT_POINTS);
   localparam int MAG_W     = 17;
   localparam logic [MAG_W-1:0] MAG_MAX = '1;

   // Sequencer step counter covers the longer of the two serial units.
   localparam int CNT_W = $clog2(ROOT_W);

   // Bar, peak and hold heights.
   localparam int HGT_W = 8;
   localparam logic [HGT_W-1:0] CLAMP_H  = 8'd128;
   localparam logic [HGT_W-1:0] HGT_FULL = '1;
   localparam int TICK_W = 16;

   // Control and status registers.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_HOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_FALL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_FALL  = 2'd2;
   localparam logic [CSR_W-1:0] PEAK_HOLD_RST = 8'd10;
   localparam logic [CSR_W-1:0] PEAK_FALL_RST = 8'd40;
   localparam logic [CSR_W-1:0] BAR_FALL_RST  = 8'd2;

   // Stream data widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Load and step strobes for a serial arithmetic unit.
   typedef struct packed {
      logic load;
      logic step;
   } serial_ctl_type;

   // Command from the sequencer to the bar and peak store.
   typedef struct packed {
      logic             attack;
      logic             fall;
      logic [BIN_W-1:0] idx;
      logic [HGT_W-1:0] half;
      logic [HGT_W-1:0] hold_frames;
      logic             peak_fall;
      logic             bar_fall;
   } store_cmd_type;

   // Current bar and peak of the addressed bin.
   typedef struct packed {
      logic [HGT_W-1:0] bar;
      logic [HGT_W-1:0] peak;
   } store_view_type;

endpackage

// ----- design/sphm_serial_square.sv -----
module sphm_serial_square (
   input  logic                           clock,
   input  sphm_pkg::serial_ctl_type       ctl,
   input  logic [sphm_pkg::COMP_W-1:0]    value,
   output logic [sphm_pkg::SQ_W-1:0]      square
);
   import sphm_pkg::*;

   logic [COMP_W-1:0] mcand_ff, mcand_in;
   logic [COMP_W-1:0] hi_ff, hi_in;
   logic [COMP_W-1:0] lo_ff, lo_in;
   logic [COMP_W:0]   partial;

   // Shift-add multiplier: one multiplier bit is retired per step, the
   // product shifts right through the high and low halves.
   always_comb begin
      partial  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (ctl.load) begin
         mcand_in = value;
         hi_in    = '0;
         lo_in    = value;
      end else if (ctl.step) begin
         hi_in = partial[COMP_W:1];
         lo_in = {partial[0], lo_ff[COMP_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign square = {hi_ff, lo_ff};

endmodule

// ----- design/sphm_serial_sqrt.sv -----
module sphm_serial_sqrt (
   input  logic                           clock,
   input  sphm_pkg::serial_ctl_type       ctl,
   input  logic [sphm_pkg::RAD_W-1:0]     radicand,
   output logic [sphm_pkg::ROOT_W-1:0]    root
);
   import sphm_pkg::*;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+1:0] rem_shift;
   logic [ROOT_W+1:0] trial;
   logic [ROOT_W+1:0] diff;

   // Restoring square root: two radicand bits enter the remainder and one
   // root bit is decided per step.
   always_comb begin
      rem_shift = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      diff      = rem_shift - trial;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (ctl.load) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (ctl.step) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = diff[ROOT_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[ROOT_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;

endmodule

// ----- design/sphm_meter_store.sv -----
module sphm_meter_store (
   input  logic                      clock,
   input  logic                      reset,
   input  sphm_pkg::store_cmd_type   cmd,
   output sphm_pkg::store_view_type  view
);
   import sphm_pkg::*;

   logic [HGT_W-1:0] bar_ff  [NBINS];
   logic [HGT_W-1:0] bar_in  [NBINS];
   logic [HGT_W-1:0] peak_ff [NBINS];
   logic [HGT_W-1:0] peak_in [NBINS];
   logic [HGT_W-1:0] hold_ff [NBINS];
   logic [HGT_W-1:0] hold_in [NBINS];
   logic [HGT_W-1:0] cur_bar;
   logic [HGT_W-1:0] cur_peak;
   logic [HGT_W-1:0] rise_bar;

   // Attack on the addressed bin, or the frame-end fall over all bins.
   always_comb begin
      cur_bar  = bar_ff[cmd.idx];
      cur_peak = peak_ff[cmd.idx];
      rise_bar = (cmd.half > cur_bar) ? cmd.half : cur_bar;
      bar_in   = bar_ff;
      peak_in  = peak_ff;
      hold_in  = hold_ff;
      if (cmd.attack) begin
         bar_in[cmd.idx] = rise_bar;
         if (rise_bar >= cur_peak) begin
            hold_in[cmd.idx] = cmd.hold_frames;
            if (rise_bar >= CLAMP_H) begin
               bar_in[cmd.idx]  = CLAMP_H;
               peak_in[cmd.idx] = CLAMP_H;
            end else begin
               peak_in[cmd.idx] = rise_bar;
            end
         end
      end else if (cmd.fall) begin
         for (int k = 0; k < NBINS; k++) begin
            if (cmd.peak_fall && peak_ff[k] != '0 && hold_ff[k] == '0) begin
               peak_in[k] = peak_ff[k] - 1'b1;
            end
            if (cmd.bar_fall && bar_ff[k] != '0) begin
               bar_in[k] = bar_ff[k] - 1'b1;
            end
            if (hold_ff[k] != '0) begin
               hold_in[k] = hold_ff[k] - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NBINS; k++) begin
            bar_ff[k]  <= '0;
            peak_ff[k] <= '0;
            hold_ff[k] <= '0;
         end
      end else begin
         bar_ff  <= bar_in;
         peak_ff <= peak_in;
         hold_ff <= hold_in;
      end
   end

   assign view.bar  = cur_bar;
   assign view.peak = cur_peak;

endmodule

// ----- design/spectrum_peak_hold_meter_unit.sv -----
// Spectrum bar and peak-hold meter. A request with tuser low is a time tick:
// it advances both fall counters and returns nothing. A request with tuser
// high is one FFT bin; it returns one response with the bin index, twice its
// complex magnitude, and the bar and peak heights after the attack. It runs
// 16 steps of the bit-serial 16-bit squarers, a root unit load, 23 steps of
// the one-bit-per-cycle square root, an attack step and an output step into
// the response register. Requests are taken again after the output step or,
// on a frame's last bin, after a fall step: holds count down, and bars and
// unheld peaks fall where their tick counter has passed its rate. A response
// still waiting in the output register holds the next bin in its output step
// until it is taken. A waiting response does not keep the next tick from
// being accepted. The user must write registers through the csr port only
// while the block is idle; the block itself does not enforce this.
module spectrum_peak_hold_meter_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: bin_word[31:0], bin_index[36:32], zero fill [39:37].
   input  logic [sphm_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: mode (0 = tick, 1 = bin).
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: out_bin[4:0], magnitude[21:5], bar_height[29:22],
   // peak_height[37:30], zero fill [39:38].
   output logic [sphm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // Register write port.
   input  logic                                csr_wr_en,
   input  logic [sphm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sphm_pkg::CSR_W-1:0]          csr_wdata
);
   import sphm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_ATTACK,
      ST_OUTPUT,
      ST_FALL
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BIN_W-1:0]  idx_ff, idx_in;
   logic              last_ff, last_in;
   logic [TICK_W-1:0] peak_tick_ff, peak_tick_in;
   logic [TICK_W-1:0] bar_tick_ff, bar_tick_in;
   logic [CSR_W-1:0]  peak_hold_ff, peak_hold_in;
   logic [CSR_W-1:0]  peak_fall_ff, peak_fall_in;
   logic [CSR_W-1:0]  bar_fall_ff, bar_fall_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]  rsp_bin_ff, rsp_bin_in;
   logic [MAG_W-1:0]  rsp_mag_ff, rsp_mag_in;
   logic [HGT_W-1:0]  rsp_bar_ff, rsp_bar_in;
   logic [HGT_W-1:0]  rsp_peak_ff, rsp_peak_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_fire;
   logic              rsp_fire;
   logic [COMP_W-1:0] re_part;
   logic [COMP_W-1:0] im_part;
   logic [COMP_W-1:0] re_abs;
   logic [COMP_W-1:0] im_abs;
   logic [SQ_W-1:0]   re_sq;
   logic [SQ_W-1:0]   im_sq;
   logic [SUM_W-1:0]  sum_sq;
   logic [RAD_W-1:0]  radicand;
   logic [ROOT_W-1:0] root;
   logic [ROOT_W-1:0] root_scaled;
   logic [MAG_W-1:0]  magnitude;
   logic [HGT_W-1:0]  half;
   serial_ctl_type    sq_ctl;
   serial_ctl_type    rt_ctl;
   store_cmd_type     cmd;
   store_view_type    view;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;

   // Magnitudes of the two signed components.
   assign re_part = req_tdata[COMP_W-1:0];
   assign im_part = req_tdata[WORD_W-1:COMP_W];
   assign re_abs  = re_part[COMP_W-1] ? (~re_part + 1'b1) : re_part;
   assign im_abs  = im_part[COMP_W-1] ? (~im_part + 1'b1) : im_part;

   assign sq_ctl.load = req_fire && req_tuser;
   assign sq_ctl.step = (state_ff == ST_SQUARE);

   sphm_serial_square u_square_re (
      .clock  (clock),
      .ctl    (sq_ctl),
      .value  (re_abs),
      .square (re_sq)
   );

   sphm_serial_square u_square_im (
      .clock  (clock),
      .ctl    (sq_ctl),
      .value  (im_abs),
      .square (im_sq)
   );

   // Scaled sum of squares feeds the root unit.
   assign sum_sq   = re_sq + im_sq;
   assign radicand = RAD_W'(sum_sq) << PRESCALE;

   assign rt_ctl.load = (state_ff == ST_SUM);
   assign rt_ctl.step = (state_ff == ST_ROOT);

   sphm_serial_sqrt u_sqrt (
      .clock    (clock),
      .ctl      (rt_ctl),
      .radicand (radicand),
      .root     (root)
   );

   // Scale the root by the FFT size and derive the saturated half height.
   assign root_scaled = root >> MAG_SHIFT;
   assign magnitude   = (root_scaled > ROOT_W'(MAG_MAX)) ? MAG_MAX
                                                         : root_scaled[MAG_W-1:0];
   assign half        = (|magnitude[MAG_W-1:HGT_W+1]) ? HGT_FULL
                                                      : magnitude[HGT_W:1];

   assign cmd.attack      = (state_ff == ST_ATTACK);
   assign cmd.fall        = (state_ff == ST_FALL);
   assign cmd.idx         = idx_ff;
   assign cmd.half        = half;
   assign cmd.hold_frames = peak_hold_ff;
   assign cmd.peak_fall   = (peak_tick_ff > TICK_W'(peak_fall_ff));
   assign cmd.bar_fall    = (bar_tick_ff > TICK_W'(bar_fall_ff));

   sphm_meter_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .view  (view)
   );

   // Sequencer next state, tick counters, registers and response slot.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      peak_tick_in = peak_tick_ff;
      bar_tick_in  = bar_tick_ff;
      peak_hold_in = peak_hold_ff;
      peak_fall_in = peak_fall_ff;
      bar_fall_in  = bar_fall_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_bar_in   = rsp_bar_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PEAK_HOLD: peak_hold_in = csr_wdata;
            CSR_PEAK_FALL: peak_fall_in = csr_wdata;
            CSR_BAR_FALL:  bar_fall_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  idx_in   = req_tdata[WORD_W +: BIN_W];
                  last_in  = req_tlast;
                  count_in = '0;
                  state_in = ST_SQUARE;
               end else begin
                  if (peak_tick_ff != '1) begin
                     peak_tick_in = peak_tick_ff + 1'b1;
                  end
                  if (bar_tick_ff != '1) begin
                     bar_tick_in = bar_tick_ff + 1'b1;
                  end
               end
            end
         end
         ST_SQUARE: begin
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(COMP_W - 1)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            count_in = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(ROOT_W - 1)) begin
               state_in = ST_ATTACK;
            end
         end
         ST_ATTACK: begin
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = idx_ff;
               rsp_mag_in   = magnitude;
               rsp_bar_in   = view.bar;
               rsp_peak_in  = view.peak;
               rsp_last_in  = last_ff;
               state_in     = last_ff ? ST_FALL : ST_IDLE;
            end
         end
         ST_FALL: begin
            if (cmd.peak_fall) begin
               peak_tick_in = '0;
            end
            if (cmd.bar_fall) begin
               bar_tick_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         last_ff      <= 1'b0;
         peak_tick_ff <= '0;
         bar_tick_ff  <= '0;
         peak_hold_ff <= PEAK_HOLD_RST;
         peak_fall_ff <= PEAK_FALL_RST;
         bar_fall_ff  <= BAR_FALL_RST;
         rsp_valid_ff <= 1'b0;
         rsp_bin_ff   <= '0;
         rsp_mag_ff   <= '0;
         rsp_bar_ff   <= '0;
         rsp_peak_ff  <= '0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         last_ff      <= last_in;
         peak_tick_ff <= peak_tick_in;
         bar_tick_ff  <= bar_tick_in;
         peak_hold_ff <= peak_hold_in;
         peak_fall_ff <= peak_fall_in;
         bar_fall_ff  <= bar_fall_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_bin_ff   <= rsp_bin_in;
         rsp_mag_ff   <= rsp_mag_in;
         rsp_bar_ff   <= rsp_bar_in;
         rsp_peak_ff  <= rsp_peak_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_peak_ff, rsp_bar_ff, rsp_mag_ff, rsp_bin_ff});

   // The attack leaves the peak dot at or above the bar.
   a_peak_over_bar: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_peak_ff >= rsp_bar_ff))
      else $error("peak height below bar height in response");

   // Heights never pass the clamp.
   a_peak_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_peak_ff <= CLAMP_H))
      else $error("peak height above clamp");

   // An accepted bin keeps the request side closed while it is worked on.
   a_bin_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> !req_tready)
      else $error("request accepted while a bin is in progress");

   // A tick never produces a response.
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("response appeared after a tick");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import sphm_pkg::*;

   // Request kinds carried on req_tuser.
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_BIN  = 1'b1;

   localparam int SETTLE_CYCLES  = 60;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int QUIET_LIMIT    = 3000;
   localparam int MAX_SHOWN      = 10;

   // One meter reading as it leaves the block.
   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic [MAG_W-1:0] mag;
      logic [HGT_W-1:0] bar;
      logic [HGT_W-1:0] peak;
      logic             last;
   } meter_reading_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_W-1:0]      csr_wdata;

   // Predicted meter state and register copies.
   logic [HGT_W-1:0]  bar_level [NBINS];
   logic [HGT_W-1:0]  peak_level [NBINS];
   logic [HGT_W-1:0]  hold_left [NBINS];
   logic [TICK_W-1:0] peak_ticks;
   logic [TICK_W-1:0] bar_ticks;
   logic [CSR_W-1:0]  hold_frames_cfg;
   logic [CSR_W-1:0]  peak_fall_cfg;
   logic [CSR_W-1:0]  bar_fall_cfg;

   meter_reading_type pending_readings[$];

   bit idle_en;
   int failures;
   int bins_sent;
   int ticks_sent;
   int readings_checked;
   int settings_used;
   int bar_fall_frames;
   int peak_fall_frames;
   int holdoff_wanted;
   int holdoff_served;
   int holdoff_left;
   int quiet_cycles;

   spectrum_peak_hold_meter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock, 12 ns period.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Integer square root, one result bit per pass from the top.
   function automatic longint unsigned int_sqrt(input longint unsigned value);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int i = 23; i >= 0; i--) begin
         trial = root | (longint'(1) << i);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Clears the predicted meter and loads the register reset values.
   function automatic void meter_clear();
      for (int k = 0; k < NBINS; k++) begin
         bar_level[k]  = '0;
         peak_level[k] = '0;
         hold_left[k]  = '0;
      end
      peak_ticks      = '0;
      bar_ticks       = '0;
      hold_frames_cfg = PEAK_HOLD_RST;
      peak_fall_cfg   = PEAK_FALL_RST;
      bar_fall_cfg    = BAR_FALL_RST;
   endfunction

   // Applies one accepted request to the predicted meter and queues any reading.
   function automatic void meter_update(input logic mode, input logic [31:0] word,
                                        input logic [BIN_W-1:0] idx, input logic last);
      longint          re;
      longint          im;
      longint unsigned power;
      longint unsigned root;
      logic [MAG_W-1:0] mag;
      logic [HGT_W-1:0] half;
      meter_reading_type reading;
      if (mode == MODE_TICK) begin
         if (peak_ticks != '1) begin
            peak_ticks++;
         end
         if (bar_ticks != '1) begin
            bar_ticks++;
         end
         return;
      end
      re    = longint'($signed(word[15:0]));
      im    = longint'($signed(word[31:16]));
      power = longint'(re * re + im * im);
      root  = int_sqrt(power << 14) >> 6;
      if (root > 131071) begin
         root = 131071;
      end
      mag  = root[MAG_W-1:0];
      half = ((mag >> 1) > 255) ? 8'd255 : mag[8:1];

      // Attack: the bar jumps up, the peak dot follows when reached.
      if (half > bar_level[idx]) begin
         bar_level[idx] = half;
      end
      if (bar_level[idx] >= peak_level[idx]) begin
         peak_level[idx] = bar_level[idx];
         hold_left[idx]  = hold_frames_cfg;
         if (bar_level[idx] >= CLAMP_H) begin
            bar_level[idx]  = CLAMP_H;
            peak_level[idx] = CLAMP_H;
         end
      end
      reading.bin  = idx;
      reading.mag  = mag;
      reading.bar  = bar_level[idx];
      reading.peak = peak_level[idx];
      reading.last = last;
      pending_readings.push_back(reading);

      // Frame end: falls once the tick counters pass their rates, then holds count down.
      if (last) begin
         if (peak_ticks > peak_fall_cfg) begin
            peak_ticks = '0;
            peak_fall_frames++;
            for (int k = 0; k < NBINS; k++) begin
               if (peak_level[k] != 0 && hold_left[k] == 0) begin
                  peak_level[k]--;
               end
            end
         end
         if (bar_ticks > bar_fall_cfg) begin
            bar_ticks = '0;
            bar_fall_frames++;
            for (int k = 0; k < NBINS; k++) begin
               if (bar_level[k] != 0) begin
                  bar_level[k]--;
               end
            end
         end
         for (int k = 0; k < NBINS; k++) begin
            if (hold_left[k] != 0) begin
               hold_left[k]--;
            end
         end
      end
   endfunction

   // Offers one request, with an occasional gap first, and waits for acceptance.
   task automatic send_req(input logic mode, input logic [31:0] word,
                           input logic [BIN_W-1:0] idx, input logic last);
      int gap;
      @(negedge clock);
      if (idle_en && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, idx, word};
      req_tuser  <= mode;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      meter_update(mode, word, idx, last);
      if (mode == MODE_TICK) begin
         ticks_sent++;
      end else begin
         bins_sent++;
      end
   endtask

   // Stops offering and waits until every predicted reading has been seen.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register; the block must be idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_PEAK_HOLD: hold_frames_cfg = value;
         CSR_PEAK_FALL: peak_fall_cfg   = value;
         CSR_BAR_FALL:  bar_fall_cfg    = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [CSR_W-1:0] hold, input logic [CSR_W-1:0] pfall,
                            input logic [CSR_W-1:0] bfall);
      wait_drained();
      write_csr(CSR_PEAK_HOLD, hold);
      write_csr(CSR_PEAK_FALL, pfall);
      write_csr(CSR_BAR_FALL, bfall);
      settings_used++;
   endtask

   // One signed component: small in half of the draws, else random, an extreme or mid-range.
   function automatic logic [15:0] rand_component();
      int          v;
      logic [15:0] c;
      v = 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            v = int'($urandom_range(0, 300)) - 150;
            c = v[15:0];
         end
         5, 6, 7: c = 16'($urandom);
         8: begin
            case ($urandom_range(0, 3))
               0: c = 16'h7FFF;
               1: c = 16'h8000;
               2: c = 16'h0000;
               default: c = 16'hFFFF;
            endcase
         end
         default: begin
            v = int'($urandom_range(0, 4000)) - 2000;
            c = v[15:0];
         end
      endcase
      return c;
   endfunction

   // Random frames: a few ticks, then a run of bins closed by frame end.
   // About one frame in ten is broken: scattered bins and random frame ends.
   task automatic run_frames(input int n_items, input int max_ticks);
      int                start_count;
      int                nticks;
      int                len;
      int                first;
      bit                noise;
      logic              last;
      logic [BIN_W-1:0]  idx;
      start_count = bins_sent + ticks_sent;
      while (bins_sent + ticks_sent - start_count < n_items) begin
         nticks = $urandom_range(0, max_ticks);
         repeat (nticks) send_req(MODE_TICK, $urandom, 5'($urandom), 1'($urandom));
         noise = ($urandom_range(0, 9) == 0);
         len   = $urandom_range(1, 12);
         first = $urandom_range(0, NBINS - 1);
         for (int j = 0; j < len; j++) begin
            idx  = noise ? 5'($urandom) : 5'((first + j) % NBINS);
            last = noise ? 1'($urandom) : (j == len - 1);
            send_req(MODE_BIN, {rand_component(), rand_component()}, idx, last);
         end
      end
   endtask

   // Field extremes, both request kinds, clamp, falls and held peaks.
   task automatic directed_test();
      send_req(MODE_BIN, 32'h0000_0000, 5'd0, 1'b0);
      send_req(MODE_BIN, 32'h0000_7FFF, 5'd31, 1'b0);
      send_req(MODE_BIN, 32'h8000_8000, 5'd1, 1'b0);
      send_req(MODE_BIN, 32'hFFFF_FFFF, 5'd2, 1'b0);
      send_req(MODE_BIN, 32'h7FFF_7FFF, 5'd3, 1'b0);
      send_req(MODE_BIN, 32'h0000_0064, 5'd4, 1'b0);
      send_req(MODE_TICK, 32'hFFFF_FFFF, 5'd31, 1'b1);
      repeat (3) send_req(MODE_TICK, 32'h0000_0000, 5'd0, 1'b0);
      // Bar falls at this frame end, the peak dot is still held.
      send_req(MODE_BIN, 32'h000A_0000, 5'd4, 1'b1);
      send_req(MODE_BIN, 32'h0000_0000, 5'd4, 1'b0);
      configure(8'd0, 8'd0, 8'd0);
      send_req(MODE_TICK, 32'h0000_0000, 5'd0, 1'b0);
      send_req(MODE_BIN, 32'h0000_0032, 5'd5, 1'b1);
      send_req(MODE_BIN, 32'h0000_0000, 5'd5, 1'b0);
      // No tick since the last fall: nothing drops here.
      send_req(MODE_BIN, 32'h0000_0000, 5'd4, 1'b1);
      send_req(MODE_BIN, 32'h0000_0000, 5'd4, 1'b0);
   endtask

   // Enough ticks to pass the highest fall rates; the frame end must then fall.
   task automatic tick_threshold_test();
      configure(8'd0, 8'd255, 8'd255);
      send_req(MODE_BIN, 32'h0000_003C, 5'd7, 1'b0);
      repeat (258) send_req(MODE_TICK, $urandom, 5'($urandom), 1'($urandom));
      send_req(MODE_BIN, 32'h0000_0000, 5'd7, 1'b1);
      send_req(MODE_BIN, 32'h0000_0000, 5'd7, 1'b0);
   endtask

   // Receiver holds off while bins keep coming, then the sender waits for all results.
   task automatic backpressure_test();
      holdoff_wanted++;
      for (int j = 0; j < 24; j++) begin
         send_req(MODE_BIN, {rand_component(), rand_component()}, 5'($urandom), 1'(j % 8 == 7));
      end
      wait_drained();
   endtask

   // Response side: random stalls plus requested long hold-offs.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else if (holdoff_served != holdoff_wanted) begin
         holdoff_served++;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(idle_en && $urandom_range(0, 99) < 9);
      end
   end

   // Compares each accepted response with the oldest predicted reading.
   always @(posedge clock) begin : check_readings
      meter_reading_type got;
      meter_reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.bin  = rsp_tdata[4:0];
         got.mag  = rsp_tdata[21:5];
         got.bar  = rsp_tdata[29:22];
         got.peak = rsp_tdata[37:30];
         got.last = rsp_tlast;
         if (pending_readings.size() == 0) begin
            failures++;
            if (failures <= MAX_SHOWN) begin
               $display("%0t: response with none pending: bin %0d mag %0d bar %0d peak %0d",
                        $realtime, got.bin, got.mag, got.bar, got.peak);
            end
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (got !== want) begin
               failures++;
               if (failures <= MAX_SHOWN) begin
                  $display("%0t: expected bin %0d mag %0d bar %0d peak %0d last %0b",
                           $realtime, want.bin, want.mag, want.bar, want.peak, want.last);
                  $display("%0t:   actual bin %0d mag %0d bar %0d peak %0d last %0b",
                           $realtime, got.bin, got.mag, got.bar, got.peak, got.last);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no handshake and no register write.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired with %0d readings outstanding", pending_readings.size());
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_TICK;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_PEAK_HOLD;
      csr_wdata  = '0;
      idle_en    = 1'b1;
      meter_clear();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_test();
      tick_threshold_test();

      configure(PEAK_HOLD_RST, PEAK_FALL_RST, BAR_FALL_RST);
      run_frames(200, 4);
      backpressure_test();

      // Long stretch with no idling on either side.
      configure(8'd0, 8'd0, 8'd0);
      idle_en = 1'b0;
      run_frames(300, 2);
      idle_en = 1'b1;

      configure(8'd255, 8'd255, 8'd255);
      run_frames(300, 40);

      repeat (3) begin
         configure(8'($urandom_range(0, 12)), 8'($urandom_range(0, 10)),
                   8'($urandom_range(0, 4)));
         run_frames(250, 3);
      end
      backpressure_test();

      wait_drained();
      $display("Sent %0d bins and %0d ticks over %0d register settings; %0d readings checked.",
               bins_sent, ticks_sent, settings_used, readings_checked);
      $display("Predicted %0d bar-fall frames and %0d peak-fall frames.",
               bar_fall_frames, peak_fall_frames);
      if (failures == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
